// ===== src/decel_speed_profile_unit_assert.svh =====
// Assertion macros shared by the checker of the speed profile unit.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef DECEL_SPEED_PROFILE_UNIT_ASSERT_SVH
`define DECEL_SPEED_PROFILE_UNIT_ASSERT_SVH

// same-cycle implication
`define DSPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dspu check failed");

// next-cycle implication
`define DSPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dspu check failed");

`endif

// ===== src/dspu_pkg.sv =====
// Shared widths, fixed-point constants and register indexes of the speed profile unit.
// No dependencies.
package dspu_pkg;
	localparam int FRAC_BITS = 16;
	localparam int SPEED_W   = 24;
	localparam int COORD_W   = 32;
	localparam int TIME_W    = 32;
	localparam int MUL_W     = 32;
	localparam int ROOT_W    = 64;
	localparam int DEN_W     = SPEED_W + 1;
	localparam int DIV_W     = (32 + FRAC_BITS > 48) ? 32 + FRAC_BITS : 48;
	// decel * 1000 > 2^F  <=>  decel > floor(2^F / 1000)
	localparam logic [SPEED_W-1:0] TINY_LIM = SPEED_W'((1 << FRAC_BITS) / 1000);
	localparam logic [SPEED_W-1:0] DECEL_RST = 24'h008000;
	localparam logic [SPEED_W-1:0] FLOOR_RST = 24'h008000;
	localparam logic [1:0] REG_START_SPEED = 2'd0;
	localparam logic [1:0] REG_DECEL_RATE  = 2'd1;
	localparam logic [1:0] REG_FLOOR_SPEED = 2'd2;
endpackage

// ===== src/dspu_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone unit; no package use.
module dspu_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	output logic              done,
	output logic [AW+BW-1:0]  prod
);
	localparam int CW = $clog2(BW);

	logic [AW-1:0] mcand_q;
	logic [AW-1:0] hi_q;
	logic [BW-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [AW:0]   sum;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : {(AW+1){1'b0}});
	assign done = done_q;
	assign prod = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= a;
			hi_q    <= '0;
			lo_q    <= b;
		end else if (busy_q) begin
			hi_q <= sum[AW:1];
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end
endmodule

// ===== src/dspu_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle (truncating).
// Standalone unit; no package use.
module dspu_sqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   rad,
	output logic           done,
	output logic [W/2-1:0] root
);
	localparam int HW = W / 2;
	localparam int CW = $clog2(HW);

	logic [W-1:0]  rad_q;
	logic [HW-1:0] root_q;
	logic [HW+1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [HW+3:0] r;
	logic [HW+3:0] trial;
	logic [HW+3:0] diff;
	logic          ge;

	assign r     = {rem_q, rad_q[W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = r >= trial;
	assign diff  = r - trial;
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(HW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[HW+1:0] : r[HW+1:0];
			root_q <= {root_q[HW-2:0], ge};
			rad_q  <= {rad_q[W-3:0], 2'b00};
		end
	end
endmodule

// ===== src/dspu_div.sv =====
// Restoring divider, one quotient bit per cycle, divisor must be nonzero.
// Standalone unit; no package use.
module dspu_div #(
	parameter int NW = 48,
	parameter int DW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   r;
	logic [DW:0]   diff;
	logic          ge;

	assign r    = {rem_q, num_q[NW-1]};
	assign ge   = r >= {1'b0, den_q};
	assign diff = r - {1'b0, den_q};
	assign done = done_q;
	assign quo  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : r[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end
endmodule

// ===== src/decel_speed_profile_unit.sv =====
// Constant-deceleration speed profile: top level with sequencer and register port.
// Uses dspu_pkg, dspu_mul, dspu_sqrt and dspu_div.
//
// Usage: waypoints (point_x, point_y, last_point) enter on the input channel
// (in_valid/in_stall); one word per waypoint leaves on the output channel
// (point_speed, arrival_time, halted, path_end) under out_valid/out_stall.
// Registers start_speed, decel_rate and floor_speed sit at 0x0, 0x4, 0x8 of
// the APB port; write them only while no waypoint is in flight.
// One waypoint is worked at a time; in_stall is high from acceptance until
// the result is loaded into the output register.
// Work per point: the first point of a path takes one serial multiply and
// one serial divide (none if decel_rate is zero); a later point takes four
// multiplies, up to two roots and at most one divide; a point past the
// stopping distance takes none. The one-bit-per-cycle multiply, root and
// divide units are used in turn.
// The output register lets the next waypoint be taken while a result waits;
// a stalled result holds, and a finished word waits in the sequencer until
// the output register frees.
// Reset clears the path state, sets decel_rate and floor_speed to 0.5 and
// start_speed to 0; the next waypoint starts a new path.
module decel_speed_profile_unit
	import dspu_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      last_point,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [SPEED_W-1:0]        point_speed,
	output logic [TIME_W-1:0]         arrival_time,
	output logic                      halted,
	output logic                      path_end,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_FIRST_MUL, ST_FIRST_DIV, ST_SQ_A, ST_SQ_B, ST_SEG_ROOT,
		ST_VI_SQ, ST_DEC_MUL, ST_VF_ROOT, ST_FLOOR, ST_TIME_DIV, ST_FINISH
	} state_t;

	state_t state_q;

	logic [SPEED_W-1:0] start_speed_q, decel_q, floor_q;

	logic signed [COORD_W-1:0] x_q, y_q, prev_x_q, prev_y_q;
	logic                      last_q;
	logic [SPEED_W-1:0]        cur_speed_q, vf_q;
	logic [TIME_W-1:0]         elapsed_q;
	logic [31:0]               travelled_q, stop_dist_q, d_q, b_q;
	logic [63:0]               s_q;
	logic [47:0]               vi2_q;
	logic                      stopped_q, first_q, floored_q;

	logic               out_valid_q, halted_q, path_end_q;
	logic [SPEED_W-1:0] speed_q;
	logic [TIME_W-1:0]  time_q;

	logic                mul_go_q, sqrt_go_q, div_go_q;
	logic [MUL_W-1:0]    mul_a_q, mul_b_q;
	logic [ROOT_W-1:0]   rad_q;
	logic [DIV_W-1:0]    num_q;
	logic [DEN_W-1:0]    den_q;
	logic                mul_done, sqrt_done, div_done;
	logic [2*MUL_W-1:0]  mul_prod;
	logic [ROOT_W/2-1:0] root;
	logic [DIV_W-1:0]    quo;

	logic        wr_en, in_acc, out_free;
	logic [32:0] dx, dy;
	logic [31:0] ax, by;
	logic [64:0] seg_sum, sub;
	logic [32:0] trav_sum, el_sum;
	logic [31:0] dt_sat;
	logic        vf_low, fl_next;
	logic [SPEED_W-1:0] vf_fl;

	dspu_mul #(.AW(MUL_W), .BW(MUL_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .prod(mul_prod)
	);

	dspu_sqrt #(.W(ROOT_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_go_q), .rad(rad_q),
		.done(sqrt_done), .root(root)
	);

	dspu_div #(.NW(DIV_W), .DW(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(num_q), .den(den_q),
		.done(div_done), .quo(quo)
	);

	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	assign out_valid    = out_valid_q;
	assign point_speed  = speed_q;
	assign arrival_time = time_q;
	assign halted       = halted_q;
	assign path_end     = path_end_q;

	always_comb begin
		case (paddr[3:2])
			REG_START_SPEED: prdata = {8'd0, start_speed_q};
			REG_DECEL_RATE:  prdata = {8'd0, decel_q};
			REG_FLOOR_SPEED: prdata = {8'd0, floor_q};
			default:         prdata = 32'd0;
		endcase
	end

	// segment deltas never exceed 2^32-1 in magnitude
	assign dx = {point_x[COORD_W-1], point_x} - {prev_x_q[COORD_W-1], prev_x_q};
	assign dy = {point_y[COORD_W-1], point_y} - {prev_y_q[COORD_W-1], prev_y_q};
	always_comb begin
		logic [32:0] nx, ny;
		nx = -dx;
		ny = -dy;
		ax = dx[32] ? nx[31:0] : dx[31:0];
		by = dy[32] ? ny[31:0] : dy[31:0];
	end

	assign seg_sum  = {1'b0, s_q} + {1'b0, mul_prod};
	assign sub      = {mul_prod, 1'b0};
	assign trav_sum = {1'b0, travelled_q} + {1'b0, d_q};
	assign vf_low   = vf_q < floor_q;
	assign vf_fl    = vf_low ? floor_q : vf_q;
	assign fl_next  = floored_q | vf_low;
	assign dt_sat   = (|quo[DIV_W-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
	assign el_sum   = {1'b0, elapsed_q} + {1'b0, dt_sat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_speed_q <= '0;
			decel_q       <= DECEL_RST;
			floor_q       <= FLOOR_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_START_SPEED: start_speed_q <= pwdata[SPEED_W-1:0];
				REG_DECEL_RATE:  decel_q       <= pwdata[SPEED_W-1:0];
				REG_FLOOR_SPEED: floor_q       <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			cur_speed_q <= '0;
			elapsed_q   <= '0;
			travelled_q <= '0;
			stop_dist_q <= '0;
			stopped_q   <= 1'b0;
			first_q     <= 1'b1;
			floored_q   <= 1'b0;
			out_valid_q <= 1'b0;
			mul_go_q    <= 1'b0;
			sqrt_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			mul_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q    <= point_x;
						y_q    <= point_y;
						last_q <= last_point;
						if (first_q) begin
							cur_speed_q <= start_speed_q;
							elapsed_q   <= '0;
							travelled_q <= '0;
							stopped_q   <= 1'b0;
							floored_q   <= 1'b0;
							first_q     <= 1'b0;
							if (decel_q == '0) begin
								stop_dist_q <= 32'hFFFF_FFFF;
								state_q     <= ST_FINISH;
							end else begin
								mul_a_q  <= MUL_W'(start_speed_q);
								mul_b_q  <= MUL_W'(start_speed_q);
								mul_go_q <= 1'b1;
								state_q  <= ST_FIRST_MUL;
							end
						end else if (stopped_q) begin
							state_q <= ST_FINISH;
						end else begin
							b_q      <= by;
							mul_a_q  <= ax;
							mul_b_q  <= ax;
							mul_go_q <= 1'b1;
							state_q  <= ST_SQ_A;
						end
					end
				end
				ST_FIRST_MUL: begin
					if (mul_done) begin
						num_q    <= DIV_W'(mul_prod[47:0]);
						den_q    <= {decel_q, 1'b0};
						div_go_q <= 1'b1;
						state_q  <= ST_FIRST_DIV;
					end
				end
				ST_FIRST_DIV: begin
					if (div_done) begin
						stop_dist_q <= dt_sat;
						state_q     <= ST_FINISH;
					end
				end
				ST_SQ_A: begin
					if (mul_done) begin
						s_q      <= mul_prod;
						mul_a_q  <= b_q;
						mul_b_q  <= b_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_SQ_B;
					end
				end
				ST_SQ_B: begin
					if (mul_done) begin
						if (seg_sum[64]) begin
							// sum of squares overflows: saturate the length
							d_q      <= 32'hFFFF_FFFF;
							mul_a_q  <= MUL_W'(cur_speed_q);
							mul_b_q  <= MUL_W'(cur_speed_q);
							mul_go_q <= 1'b1;
							state_q  <= ST_VI_SQ;
						end else begin
							rad_q     <= seg_sum[63:0];
							sqrt_go_q <= 1'b1;
							state_q   <= ST_SEG_ROOT;
						end
					end
				end
				ST_SEG_ROOT: begin
					if (sqrt_done) begin
						d_q      <= root;
						mul_a_q  <= MUL_W'(cur_speed_q);
						mul_b_q  <= MUL_W'(cur_speed_q);
						mul_go_q <= 1'b1;
						state_q  <= ST_VI_SQ;
					end
				end
				ST_VI_SQ: begin
					if (mul_done) begin
						vi2_q    <= mul_prod[47:0];
						mul_a_q  <= MUL_W'(decel_q);
						mul_b_q  <= d_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_DEC_MUL;
					end
				end
				ST_DEC_MUL: begin
					if (mul_done) begin
						if (sub > {17'd0, vi2_q}) begin
							vf_q    <= '0;
							state_q <= ST_FLOOR;
						end else begin
							rad_q     <= {16'd0, vi2_q} - sub[63:0];
							sqrt_go_q <= 1'b1;
							state_q   <= ST_VF_ROOT;
						end
					end
				end
				ST_VF_ROOT: begin
					if (sqrt_done) begin
						vf_q    <= root[SPEED_W-1:0];
						state_q <= ST_FLOOR;
					end
				end
				ST_FLOOR: begin
					travelled_q <= trav_sum[32] ? 32'hFFFF_FFFF : trav_sum[31:0];
					stopped_q   <= (trav_sum[32] ? 32'hFFFF_FFFF : trav_sum[31:0])
						> stop_dist_q;
					cur_speed_q <= vf_fl;
					floored_q   <= fl_next;
					if (!fl_next && decel_q > TINY_LIM) begin
						num_q    <= DIV_W'(cur_speed_q - vf_fl) << FRAC_BITS;
						den_q    <= {1'b0, decel_q};
						div_go_q <= 1'b1;
						state_q  <= ST_TIME_DIV;
					end else if (vf_fl == '0) begin
						// no speed left to divide by: time saturates
						elapsed_q <= 32'hFFFF_FFFF;
						state_q   <= ST_FINISH;
					end else begin
						num_q    <= DIV_W'(d_q) << FRAC_BITS;
						den_q    <= {1'b0, vf_fl};
						div_go_q <= 1'b1;
						state_q  <= ST_TIME_DIV;
					end
				end
				ST_TIME_DIV: begin
					if (div_done) begin
						elapsed_q <= el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						speed_q     <= stopped_q ? '0 : cur_speed_q;
						time_q      <= elapsed_q;
						halted_q    <= stopped_q;
						path_end_q  <= last_q;
						prev_x_q    <= x_q;
						prev_y_q    <= y_q;
						if (last_q) begin
							first_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== src/dspu_checker.sv =====
// Port-level checks for the speed profile unit, bound onto the top level.
// Uses dspu_pkg and decel_speed_profile_unit_assert.svh.
`include "decel_speed_profile_unit_assert.svh"
module dspu_checker
	import dspu_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic signed [COORD_W-1:0] point_x,
	input logic signed [COORD_W-1:0] point_y,
	input logic                      last_point,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [SPEED_W-1:0]        point_speed,
	input logic [TIME_W-1:0]         arrival_time,
	input logic                      halted,
	input logic                      path_end,
	input logic                      psel,
	input logic                      penable,
	input logic                      pwrite,
	input logic [3:0]                paddr,
	input logic [31:0]               pwdata,
	input logic [31:0]               prdata,
	input logic                      pready
);
	// one waypoint at a time: taking a word closes the input
	`DSPU_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall)
	// a halted point reports zero speed
	`DSPU_ASSERT_IMP(a_halt_zero, out_valid && halted, point_speed == '0)
	`DSPU_ASSERT_IMP(a_pready_high, psel, pready)
	`DSPU_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(point_speed) && $stable(arrival_time) && $stable(halted))
endmodule

bind decel_speed_profile_unit dspu_checker u_dspu_checker (.*);
